>>> src/mpssd_pkg.sv
// Package for the masked patch SSD best-match search.
// Types, widths and codes shared by all modules; no dependencies.
`default_nettype none

package mpssd_pkg;

   localparam int EDGE_RADIUS = 4;
   localparam int COORD_BITS  = 12;
   localparam int CHAN_BITS   = 8;
   localparam int SQ_BITS     = 2 * CHAN_BITS;
   localparam int ADD_BITS    = SQ_BITS + 2;
   localparam int COST_BITS   = 26;

   localparam logic [COST_BITS-1:0] COST_MAX     = {COST_BITS{1'b1}};
   localparam logic [COST_BITS-1:0] THRESH_RESET =
      COST_BITS'(EDGE_RADIUS * EDGE_RADIUS * 48);

   typedef enum logic [1:0] {
      MARK_MID        = 2'd0,
      MARK_BLOCK_END  = 2'd1,
      MARK_ROW_END    = 2'd2,
      MARK_SEARCH_END = 2'd3
   } mark_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cand_x;
      logic [COORD_BITS-1:0] cand_y;
      logic [CHAN_BITS-1:0]  src_blue;
      logic [CHAN_BITS-1:0]  src_green;
      logic [CHAN_BITS-1:0]  src_red;
      logic [CHAN_BITS-1:0]  dst_blue;
      logic [CHAN_BITS-1:0]  dst_green;
      logic [CHAN_BITS-1:0]  dst_red;
      logic                  src_in_hole;
      logic                  dst_known;
      mark_type              pixel_mark;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [COORD_BITS-1:0] best_x;
      logic [COORD_BITS-1:0] best_y;
      logic [COST_BITS-1:0]  best_cost;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/mpssd_pixel_cost.sv
// Per-pixel cost: sum of squared B, G and R differences of one pixel pair.
// Uses mpssd_pkg for the item type and widths.
`default_nettype none

module mpssd_pixel_cost (
   input  mpssd_pkg::req_type                  item,
   output logic [mpssd_pkg::ADD_BITS-1:0]      pixel_cost
);

   function automatic logic [mpssd_pkg::SQ_BITS-1:0] sq_diff(
      input logic [mpssd_pkg::CHAN_BITS-1:0] a,
      input logic [mpssd_pkg::CHAN_BITS-1:0] b
   );
      logic [mpssd_pkg::CHAN_BITS-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return mpssd_pkg::SQ_BITS'(d) * mpssd_pkg::SQ_BITS'(d);
   endfunction

   logic [mpssd_pkg::SQ_BITS-1:0] sq_b;
   logic [mpssd_pkg::SQ_BITS-1:0] sq_g;
   logic [mpssd_pkg::SQ_BITS-1:0] sq_r;

   always_comb begin
      sq_b       = sq_diff(item.src_blue,  item.dst_blue);
      sq_g       = sq_diff(item.src_green, item.dst_green);
      sq_r       = sq_diff(item.src_red,   item.dst_red);
      pixel_cost = mpssd_pkg::ADD_BITS'(sq_b) + mpssd_pkg::ADD_BITS'(sq_g)
                 + mpssd_pkg::ADD_BITS'(sq_r);
   end

endmodule

`default_nettype wire

>>> src/mpssd_search.sv
// Search state: running block cost, best candidate and early-stop flag.
// Uses mpssd_pkg; takes the pixel cost from mpssd_pixel_cost.
`default_nettype none

module mpssd_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  mpssd_pkg::req_type                  item,
   input  logic [mpssd_pkg::ADD_BITS-1:0]      pixel_cost,
   input  logic [mpssd_pkg::COST_BITS-1:0]     threshold,
   output mpssd_pkg::rsp_type                  result
);

   logic [mpssd_pkg::COST_BITS-1:0]  running_cost_ff, running_cost_in;
   logic                             block_invalid_ff, block_invalid_in;
   logic [mpssd_pkg::COST_BITS-1:0]  best_cost_ff, best_cost_in;
   logic                             best_valid_ff, best_valid_in;
   logic [mpssd_pkg::COORD_BITS-1:0] best_col_ff, best_col_in;
   logic [mpssd_pkg::COORD_BITS-1:0] best_row_ff, best_row_in;
   logic                             stopped_ff, stopped_in;

   logic                             inv_now;
   logic [mpssd_pkg::COST_BITS:0]    sum;
   logic [mpssd_pkg::COST_BITS-1:0]  cost_now;
   logic                             take;

   always_comb begin
      running_cost_in  = running_cost_ff;
      block_invalid_in = block_invalid_ff;
      best_cost_in     = best_cost_ff;
      best_valid_in    = best_valid_ff;
      best_col_in      = best_col_ff;
      best_row_in      = best_row_ff;
      stopped_in       = stopped_ff;

      inv_now  = block_invalid_ff | item.src_in_hole;
      sum      = {1'b0, running_cost_ff} + (mpssd_pkg::COST_BITS + 1)'(pixel_cost);
      cost_now = running_cost_ff;
      if (item.dst_known && !inv_now) begin
         cost_now = sum[mpssd_pkg::COST_BITS] ? mpssd_pkg::COST_MAX
                                              : sum[mpssd_pkg::COST_BITS-1:0];
      end
      take = !inv_now && (!best_valid_ff || cost_now <= best_cost_ff);

      if (!stopped_ff) begin
         running_cost_in  = cost_now;
         block_invalid_in = inv_now;
         if (item.pixel_mark != mpssd_pkg::MARK_MID) begin
            if (take) begin
               best_valid_in = 1'b1;
               best_cost_in  = cost_now;
               best_col_in   = item.cand_x;
               best_row_in   = item.cand_y;
            end
            running_cost_in  = '0;
            block_invalid_in = 1'b0;
         end
         if (item.pixel_mark == mpssd_pkg::MARK_ROW_END && best_valid_in
             && best_cost_in < threshold) begin
            stopped_in = 1'b1;
         end
      end

      result.found     = best_valid_in;
      result.best_x    = best_valid_in ? best_col_in  : '0;
      result.best_y    = best_valid_in ? best_row_in  : '0;
      result.best_cost = best_valid_in ? best_cost_in : '0;

      if (item.pixel_mark == mpssd_pkg::MARK_SEARCH_END) begin
         running_cost_in  = '0;
         block_invalid_in = 1'b0;
         best_cost_in     = '0;
         best_valid_in    = 1'b0;
         best_col_in      = '0;
         best_row_in      = '0;
         stopped_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_cost_ff  <= '0;
         block_invalid_ff <= 1'b0;
         best_cost_ff     <= '0;
         best_valid_ff    <= 1'b0;
         best_col_ff      <= '0;
         best_row_ff      <= '0;
         stopped_ff       <= 1'b0;
      end else if (step) begin
         running_cost_ff  <= running_cost_in;
         block_invalid_ff <= block_invalid_in;
         best_cost_ff     <= best_cost_in;
         best_valid_ff    <= best_valid_in;
         best_col_ff      <= best_col_in;
         best_row_ff      <= best_row_in;
         stopped_ff       <= stopped_in;
      end
   end

   // early stop only follows a row end with a best candidate in hand
   a_stop_has_best: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> best_valid_ff)
      else $error("stopped without a best candidate");

   a_stop_block_clear: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> (running_cost_ff == '0 && !block_invalid_ff))
      else $error("block state not clear while stopped");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && item.pixel_mark == mpssd_pkg::MARK_SEARCH_END)
      |=> (!best_valid_ff && !stopped_ff))
      else $error("search state not cleared after search end");

endmodule

`default_nettype wire

>>> src/masked_patch_ssd_best_match.sv
// Top level of the masked patch SSD best-match search.
// Uses mpssd_pkg, mpssd_pixel_cost and mpssd_search.
//
// Usage:
//   req_*: one transfer per pixel pair (candidate corner, source and target
//   BGR, in-hole and known flags, pixel mark). pixel_mark closes a block,
//   a block and row, or the whole search.
//   rsp_*: one transfer per search, on the search-end pixel: found flag,
//   best corner and best cost. No other pixel produces a transfer.
//   csr_*: write of the early-stop threshold; write only while idle.
// Timing:
//   One pixel per cycle sustained while no search-end pixel waits on a
//   stalled response. A pixel sits in the input register, where squares,
//   saturating accumulate and best compare are done in a single
//   combinational pass; the search-end result is then registered, and
//   rsp_valid comes from that output register.
// Reset clears search state and rsp_valid, and loads threshold 768.
// A stalled response holds; while it is held, only a search-end pixel
// waits in the input register, and req_stall rises until rsp is taken.
`default_nettype none

module masked_patch_ssd_best_match (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mpssd_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mpssd_pkg::rsp_type              rsp_data,
   input  logic                            csr_wr_en,
   input  logic [mpssd_pkg::COST_BITS-1:0] csr_wr_data
);

   logic                            s1_valid_ff, s1_valid_in;
   mpssd_pkg::req_type              s1_data_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   mpssd_pkg::rsp_type              rsp_data_ff;
   logic [mpssd_pkg::COST_BITS-1:0] thresh_ff;

   logic                            out_free;
   logic                            is_end;
   logic                            advance;
   logic [mpssd_pkg::ADD_BITS-1:0]  pixel_cost;
   mpssd_pkg::rsp_type              result;

   mpssd_pixel_cost u_cost (
      .item       (s1_data_ff),
      .pixel_cost (pixel_cost)
   );

   mpssd_search u_search (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (s1_data_ff),
      .pixel_cost (pixel_cost),
      .threshold  (thresh_ff),
      .result     (result)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      is_end       = s1_data_ff.pixel_mark == mpssd_pkg::MARK_SEARCH_END;
      advance      = s1_valid_ff && (!is_end || out_free);
      req_stall    = s1_valid_ff && !advance;
      s1_valid_in  = (req_valid && !req_stall) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (advance && is_end) ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
      rsp_valid    = rsp_valid_ff;
      rsp_data     = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= mpssd_pkg::THRESH_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (advance && is_end) begin
         rsp_data_ff <= result;
      end
   end

endmodule

`default_nettype wire

>>> verif/masked_patch_ssd_best_match_test.sv
// Self-checking testbench for masked_patch_ssd_best_match.
// Drives pixel transfers, predicts each search result in place and checks it
// field by field; depends on mpssd_pkg and the top level only.
`timescale 1ns / 100ps

module masked_patch_ssd_best_match_test;

   localparam int RANDOM_PIXELS = 320;
   localparam int SAT_PIXELS    = 345;
   localparam int IDLE_CYCLES   = 4;

   logic                           clock;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   mpssd_pkg::req_type             req_data    = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   mpssd_pkg::rsp_type             rsp_data;
   logic                           csr_wr_en   = 1'b0;
   logic [mpssd_pkg::COST_BITS-1:0] csr_wr_data = '0;

   masked_patch_ssd_best_match DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // search model state
   logic [mpssd_pkg::COST_BITS-1:0]  stop_thresh;
   logic [mpssd_pkg::COST_BITS-1:0]  acc_cost;
   logic                             acc_invalid;
   logic [mpssd_pkg::COST_BITS-1:0]  best_cost_m;
   logic                             best_seen;
   logic [mpssd_pkg::COORD_BITS-1:0] best_col_m;
   logic [mpssd_pkg::COORD_BITS-1:0] best_row_m;
   logic                             stopped;

   mpssd_pkg::rsp_type expected_results[$];

   int errors        = 0;
   int live_pixels   = 0;
   int pixels_sent   = 0;
   int results_seen  = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_len      = 0;
   int hold_left     = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [mpssd_pkg::SQ_BITS-1:0] sq_diff(
      logic [mpssd_pkg::CHAN_BITS-1:0] a,
      logic [mpssd_pkg::CHAN_BITS-1:0] b);
      logic [mpssd_pkg::SQ_BITS-1:0] d;
      d = mpssd_pkg::SQ_BITS'((a > b) ? a - b : b - a);
      return d * d;
   endfunction

   function automatic void clear_search();
      acc_cost    = '0;
      acc_invalid = 1'b0;
      best_cost_m = '0;
      best_seen   = 1'b0;
      best_col_m  = '0;
      best_row_m  = '0;
      stopped     = 1'b0;
   endfunction

   function automatic void predict_pixel(mpssd_pkg::req_type p);
      logic [31:0]        sum;
      mpssd_pkg::rsp_type r;
      if (!stopped || p.pixel_mark == mpssd_pkg::MARK_SEARCH_END) live_pixels++;
      if (!stopped) begin
         if (p.src_in_hole) acc_invalid = 1'b1;
         if (p.dst_known && !acc_invalid) begin
            sum = 32'(acc_cost) + sq_diff(p.src_blue, p.dst_blue) +
                  sq_diff(p.src_green, p.dst_green) + sq_diff(p.src_red, p.dst_red);
            acc_cost = (sum > 32'(mpssd_pkg::COST_MAX)) ? mpssd_pkg::COST_MAX
                                                        : sum[mpssd_pkg::COST_BITS-1:0];
         end
         if (p.pixel_mark != mpssd_pkg::MARK_MID) begin
            if (!acc_invalid && (!best_seen || acc_cost <= best_cost_m)) begin
               best_seen   = 1'b1;
               best_cost_m = acc_cost;
               best_col_m  = p.cand_x;
               best_row_m  = p.cand_y;
            end
            acc_cost    = '0;
            acc_invalid = 1'b0;
         end
         if (p.pixel_mark == mpssd_pkg::MARK_ROW_END && best_seen
             && best_cost_m < stop_thresh)
            stopped = 1'b1;
      end
      if (p.pixel_mark == mpssd_pkg::MARK_SEARCH_END) begin
         r.found     = best_seen;
         r.best_x    = best_seen ? best_col_m : '0;
         r.best_y    = best_seen ? best_row_m : '0;
         r.best_cost = best_seen ? best_cost_m : '0;
         expected_results.insert(expected_results.size(), r);
         clear_search();
      end
   endfunction

   function automatic mpssd_pkg::req_type make_pixel(
      logic [mpssd_pkg::COORD_BITS-1:0] x, logic [mpssd_pkg::COORD_BITS-1:0] y,
      logic [7:0] sb, logic [7:0] sg, logic [7:0] sr,
      logic [7:0] db, logic [7:0] dg, logic [7:0] dr,
      logic hole, logic known, mpssd_pkg::mark_type mark);
      mpssd_pkg::req_type p;
      p.cand_x      = x;
      p.cand_y      = y;
      p.src_blue    = sb;
      p.src_green   = sg;
      p.src_red     = sr;
      p.dst_blue    = db;
      p.dst_green   = dg;
      p.dst_red     = dr;
      p.src_in_hole = hole;
      p.dst_known   = known;
      p.pixel_mark  = mark;
      return p;
   endfunction

   function automatic mpssd_pkg::req_type random_pixel(
      logic [mpssd_pkg::COORD_BITS-1:0] x,
      logic [mpssd_pkg::COORD_BITS-1:0] y,
      bit near, mpssd_pkg::mark_type mark);
      mpssd_pkg::req_type p;
      p.cand_x      = x;
      p.cand_y      = y;
      p.dst_blue    = 8'($urandom);
      p.dst_green   = 8'($urandom);
      p.dst_red     = 8'($urandom);
      p.src_blue    = near ? p.dst_blue  ^ 8'($urandom_range(0, 3)) : 8'($urandom);
      p.src_green   = near ? p.dst_green ^ 8'($urandom_range(0, 3)) : 8'($urandom);
      p.src_red     = near ? p.dst_red   ^ 8'($urandom_range(0, 3)) : 8'($urandom);
      p.src_in_hole = ($urandom_range(99) < 4);
      p.dst_known   = ($urandom_range(99) < 85);
      p.pixel_mark  = mark;
      return p;
   endfunction

   // valid stays high across back-to-back transfers; it only drops on idle
   task automatic send_pixel(mpssd_pkg::req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(p);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [mpssd_pkg::COST_BITS-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      stop_thresh = value;
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_len != 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      mpssd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result transfer with no expected result pending");
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
               errors++;
            end
            if (rsp_data.best_x !== want.best_x) begin
               $error("best_x: expected %0d, actual %0d", want.best_x, rsp_data.best_x);
               errors++;
            end
            if (rsp_data.best_y !== want.best_y) begin
               $error("best_y: expected %0d, actual %0d", want.best_y, rsp_data.best_y);
               errors++;
            end
            if (rsp_data.best_cost !== want.best_cost) begin
               $error("best_cost: expected %0d, actual %0d", want.best_cost,
                      rsp_data.best_cost);
               errors++;
            end
         end
      end
   end

   task automatic test_empty_search();
      send_pixel(make_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                            1'b0, 1'b1, mpssd_pkg::MARK_SEARCH_END));
      send_pixel(make_pixel(12'd9, 12'd9, 8'd1, 8'd2, 8'd3, 8'd1, 8'd2, 8'd3,
                            1'b1, 1'b1, mpssd_pkg::MARK_BLOCK_END));
      send_pixel(make_pixel(12'd8, 12'd8, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5,
                            1'b1, 1'b1, mpssd_pkg::MARK_SEARCH_END));
   endtask

   task automatic test_cost_and_ties();
      send_pixel(make_pixel(12'hFFF, 12'h000, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                            1'b0, 1'b1, mpssd_pkg::MARK_MID));
      send_pixel(make_pixel(12'hFFF, 12'h000, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                            1'b0, 1'b1, mpssd_pkg::MARK_BLOCK_END));
      send_pixel(make_pixel(12'h000, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                            1'b0, 1'b1, mpssd_pkg::MARK_MID));
      send_pixel(make_pixel(12'h000, 12'hFFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                            1'b0, 1'b1, mpssd_pkg::MARK_BLOCK_END));
      // unknown target pixel adds nothing
      send_pixel(make_pixel(12'd123, 12'd456, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                            1'b0, 1'b0, mpssd_pkg::MARK_MID));
      send_pixel(make_pixel(12'd123, 12'd456, 8'd10, 8'd20, 8'd30, 8'd11, 8'd21, 8'd31,
                            1'b0, 1'b1, mpssd_pkg::MARK_BLOCK_END));
      // hole mid block invalidates a zero-cost block
      send_pixel(make_pixel(12'd7, 12'd7, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
                            1'b1, 1'b1, mpssd_pkg::MARK_MID));
      send_pixel(make_pixel(12'd7, 12'd7, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
                            1'b0, 1'b1, mpssd_pkg::MARK_BLOCK_END));
      // search end closes a block tying the best; later one wins
      send_pixel(make_pixel(12'hFFF, 12'hFFF, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2,
                            1'b0, 1'b1, mpssd_pkg::MARK_SEARCH_END));
      // row end above threshold keeps searching
      send_pixel(make_pixel(12'd300, 12'd301, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                            1'b0, 1'b1, mpssd_pkg::MARK_ROW_END));
      send_pixel(make_pixel(12'd302, 12'd303, 8'd0, 8'd1, 8'd2, 8'd1, 8'd3, 8'd2,
                            1'b0, 1'b1, mpssd_pkg::MARK_SEARCH_END));
   endtask

   task automatic test_early_stop();
      send_pixel(make_pixel(12'd100, 12'd200, 8'd2, 8'd2, 8'd2, 8'd0, 8'd0, 8'd0,
                            1'b0, 1'b1, mpssd_pkg::MARK_ROW_END));
      send_pixel(make_pixel(12'd1, 12'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                            1'b0, 1'b1, mpssd_pkg::MARK_BLOCK_END));
      send_pixel(make_pixel(12'd2, 12'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                            1'b0, 1'b1, mpssd_pkg::MARK_ROW_END));
      send_pixel(make_pixel(12'd3, 12'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                            1'b0, 1'b1, mpssd_pkg::MARK_SEARCH_END));
      write_threshold('0);
      send_pixel(make_pixel(12'd5, 12'd5, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9,
                            1'b0, 1'b1, mpssd_pkg::MARK_ROW_END));
      send_pixel(make_pixel(12'd6, 12'd6, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9,
                            1'b0, 1'b1, mpssd_pkg::MARK_SEARCH_END));
      // cost equal to threshold does not stop
      write_threshold(26'd13);
      send_pixel(make_pixel(12'd40, 12'd41, 8'd2, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0,
                            1'b0, 1'b1, mpssd_pkg::MARK_ROW_END));
      send_pixel(make_pixel(12'd42, 12'd43, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                            1'b0, 1'b1, mpssd_pkg::MARK_ROW_END));
      send_pixel(make_pixel(12'd44, 12'd45, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                            1'b0, 1'b1, mpssd_pkg::MARK_SEARCH_END));
   endtask

   // one block of full-swing pixels runs the cost into the 26-bit limit
   task automatic test_saturation();
      write_threshold(mpssd_pkg::COST_MAX);
      for (int i = 0; i < SAT_PIXELS; i++)
         send_pixel(make_pixel(12'd11, 12'd22, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                               1'b0, 1'b1, (i == SAT_PIXELS-1) ? mpssd_pkg::MARK_ROW_END
                                                               : mpssd_pkg::MARK_MID));
      send_pixel(make_pixel(12'd33, 12'd44, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                            1'b1, 1'b1, mpssd_pkg::MARK_SEARCH_END));
   endtask

   task automatic send_random_search();
      int rows;
      int blocks;
      int pix;
      bit near;
      bit last_row;
      bit last_blk;
      logic [mpssd_pkg::COORD_BITS-1:0] x;
      logic [mpssd_pkg::COORD_BITS-1:0] y;
      mpssd_pkg::mark_type mark;
      if ($urandom_range(99) < 10) begin
         pix = $urandom_range(1, 8);
         for (int i = 0; i < pix; i++)
            send_pixel(random_pixel(mpssd_pkg::COORD_BITS'($urandom),
                                    mpssd_pkg::COORD_BITS'($urandom),
                                    1'($urandom_range(1)),
                                    mpssd_pkg::mark_type'($urandom_range(0, 3))));
         return;
      end
      rows = $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
         blocks = $urandom_range(1, 3);
         last_row = (r == rows - 1);
         for (int b = 0; b < blocks; b++) begin
            last_blk = (b == blocks - 1);
            x = mpssd_pkg::COORD_BITS'($urandom);
            y = mpssd_pkg::COORD_BITS'($urandom);
            near = ($urandom_range(99) < 60);
            pix = $urandom_range(1, 6);
            for (int i = 0; i < pix; i++) begin
               if (i < pix - 1)            mark = mpssd_pkg::MARK_MID;
               else if (!last_blk)         mark = mpssd_pkg::MARK_BLOCK_END;
               else if (!last_row)         mark = mpssd_pkg::MARK_ROW_END;
               else                        mark = mpssd_pkg::MARK_SEARCH_END;
               send_pixel(random_pixel(x, y, near, mark));
            end
         end
      end
   endtask

   task automatic test_random();
      int idle_pct[4]  = '{0, 47, 0, 35};
      int stall_p[4]   = '{0, 0, 47, 35};
      logic [mpssd_pkg::COST_BITS-1:0] thresh_set[4];
      int goal;
      thresh_set = '{mpssd_pkg::THRESH_RESET, '0,
                     mpssd_pkg::COST_BITS'($urandom_range(1, 3000)), mpssd_pkg::COST_MAX};
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(thresh_set[ph]);
         send_idle_pct = idle_pct[ph];
         stall_pct     = stall_p[ph];
         goal = live_pixels + RANDOM_PIXELS / 4;
         while (live_pixels < goal) send_random_search();
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_threshold(mpssd_pkg::THRESH_RESET);
      hold_len = 300;
      for (int i = 0; i < 30; i++) begin
         send_pixel(random_pixel(mpssd_pkg::COORD_BITS'($urandom),
                                 mpssd_pkg::COORD_BITS'($urandom), 1'b1,
                                 mpssd_pkg::MARK_MID));
         send_pixel(random_pixel(mpssd_pkg::COORD_BITS'($urandom),
                                 mpssd_pkg::COORD_BITS'($urandom), 1'b1,
                                 mpssd_pkg::MARK_SEARCH_END));
      end
      wait_idle();
   endtask

   initial begin
      stop_thresh = mpssd_pkg::THRESH_RESET;
      clear_search();
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_search();
      test_cost_and_ties();
      test_early_stop();
      test_saturation();
      test_random();
      test_backpressure();
      req_valid <= 1'b0;
      stall_pct = 0;
      for (int n = 0; n < 5000 && expected_results.size() != 0; n++) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         errors++;
      end
      $display("run covered %0d pixel transfers and %0d search results,", pixels_sent,
               results_seen);
      $display("with ties, holes, saturation, early stop and output hold-off; %0d errors",
               errors);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
